### hdl/assert_macros.svh
// assertion macros used by key_click_classifier_top
// no dependencies; pulled in by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define KCC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define KCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/kcc_pkg.sv
// types and constants for the key click classifier
// no dependencies; imported by key_click_classifier_top and the bench files
package kcc_pkg;

    // configuration register indexes (word address)
    localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [1:0] REG_LONG_LIMIT     = 2'd1;
    localparam logic [1:0] REG_DOUBLE_WINDOW  = 2'd2;

    // register reset values
    localparam logic [7:0] DEBOUNCE_RESET = 8'd2;
    localparam logic [7:0] LONG_RESET     = 8'd69;
    localparam logic [7:0] WINDOW_RESET   = 8'd20;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // one result transaction
    typedef struct packed {
        logic single_click;
        logic double_click;
        logic long_press;
    } result_t;

    // saturating increment of an 8-bit counter
    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        logic [7:0] r;
        r = (v == COUNT_MAX) ? v : v + 8'd1;
        return r;
    endfunction

endpackage

### hdl/key_click_classifier_top.sv
// key click classifier: single, double and long press events from one key
// depends on kcc_pkg and assert_macros.svh
`include "assert_macros.svh"

// Accepts key samples and returns exactly one result transaction per sample
// (single_click, double_click, long_press pulses). Each sample is classified in the
// cycle it is accepted: the classifier state registers and a single level of
// counter/compare logic feed a result register, so the throughput is one sample per
// cycle while s_ready is high. A two-entry output buffer (result register plus a skid
// register) lets a sample be taken while a finished result still waits; s_ready drops
// only when both entries are full. The user must write the three thresholds over the
// APB port at byte addresses 0 (debounce_ticks), 4 (long_limit) and 8 (double_window)
// only while no transaction is in flight; the block does not enforce this.
module key_click_classifier_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_key_down,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_single_click,
    output logic        m_double_click,
    output logic        m_long_press,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kcc_pkg::*;

    logic [7:0] debounce_reg, long_reg, window_reg;
    logic [7:0] hold_count_reg, hold_count_next;
    logic       press_seen_reg, press_seen_next;
    logic       window_open_reg, window_open_next;
    logic [7:0] window_count_reg, window_count_next;

    result_t    res_calc;
    result_t    out_reg, skid_reg;
    logic       out_valid_reg, skid_valid_reg;

    logic       in_accept, out_load, skid_load, skid_move;
    logic       cfg_write;
    logic [7:0] hold_inc, win_inc;
    logic       lng, dbl;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            long_reg     <= LONG_RESET;
            window_reg   <= WINDOW_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_DEBOUNCE_TICKS: debounce_reg <= pwdata[7:0];
                REG_LONG_LIMIT:     long_reg     <= pwdata[7:0];
                REG_DOUBLE_WINDOW:  window_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            REG_DEBOUNCE_TICKS: prdata = {24'd0, debounce_reg};
            REG_LONG_LIMIT:     prdata = {24'd0, long_reg};
            REG_DOUBLE_WINDOW:  prdata = {24'd0, window_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // handshake
    assign s_ready   = !skid_valid_reg;
    assign in_accept = s_valid && s_ready;

    // classify one tick
    always_comb begin
        hold_count_next   = hold_count_reg;
        press_seen_next   = press_seen_reg;
        window_open_next  = window_open_reg;
        window_count_next = window_count_reg;
        res_calc          = '0;
        hold_inc          = sat_inc(hold_count_reg);
        win_inc           = 8'd0;
        lng               = 1'b0;
        dbl               = 1'b0;
        if (s_key_down) begin
            // key held: count hold time, recognise press at debounce count
            hold_count_next = hold_inc;
            if (hold_inc == debounce_reg) begin
                press_seen_next = 1'b1;
            end
        end else begin
            // release tick
            lng = hold_count_reg > long_reg;
            dbl = press_seen_reg && window_open_reg;
            if (dbl) begin
                window_open_next  = 1'b0;
                window_count_next = 8'd0;
            end else if (press_seen_reg && !lng) begin
                window_open_next = 1'b1;
            end
            // window runs only while key is up
            if (window_open_next) begin
                win_inc = sat_inc(window_count_next);
                if (win_inc > window_reg) begin
                    res_calc.single_click = 1'b1;
                    window_count_next     = 8'd0;
                    window_open_next      = 1'b0;
                end else begin
                    window_count_next = win_inc;
                end
            end
            res_calc.double_click = dbl;
            res_calc.long_press   = lng;
            hold_count_next       = 8'd0;
            press_seen_next       = 1'b0;
        end
    end

    // classifier state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_count_reg   <= 8'd0;
            press_seen_reg   <= 1'b0;
            window_open_reg  <= 1'b0;
            window_count_reg <= 8'd0;
        end else if (in_accept) begin
            hold_count_reg   <= hold_count_next;
            press_seen_reg   <= press_seen_next;
            window_open_reg  <= window_open_next;
            window_count_reg <= window_count_next;
        end
    end

    // output buffer: result register plus skid entry
    assign skid_move = skid_valid_reg && m_ready;
    assign out_load  = in_accept && (!out_valid_reg || m_ready);
    assign skid_load = in_accept && out_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_move) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (skid_load) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (skid_move) begin
            out_reg <= skid_reg;
        end else if (out_load) begin
            out_reg <= res_calc;
        end
        if (skid_load) begin
            skid_reg <= res_calc;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_single_click = out_reg.single_click;
    assign m_double_click = out_reg.double_click;
    assign m_long_press   = out_reg.long_press;

    // checks
    `KCC_ASSERT(a_skid_needs_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg,
        "skid entry full while result register empty")
    `KCC_ASSERT(a_dbl_no_single, aclk, aresetn,
        m_valid |-> !(m_double_click && m_single_click),
        "double click and single click in one transaction")
    `KCC_ASSERT(a_release_clears, aclk, aresetn,
        (in_accept && !s_key_down) |=> (hold_count_reg == 8'd0 && !press_seen_reg),
        "hold state not cleared on release")

endmodule

### bench/kcc_result_checker.sv
`timescale 1ns / 1ps
// result checker for the key click classifier: tracks thresholds from apb writes,
// predicts one event transaction per key tick and compares it with the result channel
// depends on kcc_pkg (result_t, register indexes, reset values)
module kcc_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_key_down,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_single_click,
    input  logic        m_double_click,
    input  logic        m_long_press,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          outstanding,
    output int          singles_seen,
    output int          doubles_seen,
    output int          longs_seen
);
    import kcc_pkg::*;

    // threshold shadow copies
    logic [7:0] cfg_debounce;
    logic [7:0] cfg_long;
    logic [7:0] cfg_window;

    // classifier state mirror
    logic [7:0] hold_cnt;
    logic       pressed;
    logic       win_open;
    logic [7:0] win_cnt;

    result_t click_queue[$];
    result_t seen;
    result_t want;
    int      errors = 0;

    // one key tick through the classifier, returns the events of that tick
    function automatic result_t classify_tick(input logic key);
        result_t r;
        logic    is_long;
        r = '0;
        if (key) begin
            if (hold_cnt != COUNT_MAX) hold_cnt = hold_cnt + 8'd1;
            if (hold_cnt == cfg_debounce) pressed = 1'b1;
        end else begin
            is_long = hold_cnt > cfg_long;
            r.long_press = is_long;
            // second recognized press inside the window
            if (pressed && win_open) begin
                r.double_click = 1'b1;
                pressed  = 1'b0;
                win_open = 1'b0;
                win_cnt  = 8'd0;
            end
            if (pressed && !is_long) win_open = 1'b1;
            // window only runs while the key is up
            if (win_open) begin
                if (win_cnt != COUNT_MAX) win_cnt = win_cnt + 8'd1;
                if (win_cnt > cfg_window) begin
                    r.single_click = 1'b1;
                    win_cnt  = 8'd0;
                    win_open = 1'b0;
                end
            end
            hold_cnt = 8'd0;
            pressed  = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic exp_v, input logic act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %b actual %b", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_debounce = DEBOUNCE_RESET;
            cfg_long     = LONG_RESET;
            cfg_window   = WINDOW_RESET;
            hold_cnt     = 8'd0;
            pressed      = 1'b0;
            win_open     = 1'b0;
            win_cnt      = 8'd0;
            singles_seen = 0;
            doubles_seen = 0;
            longs_seen   = 0;
            click_queue.delete();
        end else begin
            // result transaction against the oldest prediction
            if (m_valid && m_ready) begin
                seen = {m_single_click, m_double_click, m_long_press};
                if (click_queue.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %b",
                             $time, seen);
                    errors++;
                end else begin
                    want = click_queue.pop_front();
                    check_field("single_click", want.single_click, seen.single_click);
                    check_field("double_click", want.double_click, seen.double_click);
                    check_field("long_press", want.long_press, seen.long_press);
                end
                if (seen.single_click === 1'b1) singles_seen++;
                if (seen.double_click === 1'b1) doubles_seen++;
                if (seen.long_press === 1'b1) longs_seen++;
            end
            // key tick transaction
            if (s_valid && s_ready) click_queue.push_back(classify_tick(s_key_down));
            // threshold register write
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_DEBOUNCE_TICKS: cfg_debounce = pwdata[7:0];
                    REG_LONG_LIMIT:     cfg_long     = pwdata[7:0];
                    REG_DOUBLE_WINDOW:  cfg_window   = pwdata[7:0];
                    default: ;
                endcase
            end
        end
        fail_count  <= errors;
        outstanding <= click_queue.size();
    end

endmodule

### bench/tb_key_click_classifier_top.sv
`timescale 1ns / 1ps
// testbench top for the key click classifier: clock, reset, apb threshold writes,
// key tick stimulus and random result back-pressure; verdict from kcc_result_checker
// depends on kcc_pkg, kcc_result_checker and key_click_classifier_top
module tb_key_click_classifier_top;
    import kcc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_key_down;
    logic        m_valid;
    logic        m_ready;
    logic        m_single_click;
    logic        m_double_click;
    logic        m_long_press;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;
    int singles_seen;
    int doubles_seen;
    int longs_seen;

    int ticks_sent    = 0;
    int settings_used = 0;
    int results_taken = 0;
    bit tx_steady     = 1'b0;
    int cfg_deb;
    int cfg_lim;
    int cfg_win;

    // directed ticks: idle, single click, double click, long press, double plus long
    bit press_script [0:21] = '{1'b0,
                                1'b1, 1'b0, 1'b0, 1'b0,
                                1'b1, 1'b0, 1'b1, 1'b0,
                                1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                                1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

    always #4 aclk = ~aclk;

    key_click_classifier_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_down     (s_key_down),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_single_click (m_single_click),
        .m_double_click (m_double_click),
        .m_long_press   (m_long_press),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    kcc_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_down     (s_key_down),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_single_click (m_single_click),
        .m_double_click (m_double_click),
        .m_long_press   (m_long_press),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .singles_seen   (singles_seen),
        .doubles_seen   (doubles_seen),
        .longs_seen     (longs_seen)
    );

    // one key tick transaction with a random lead-in gap
    task automatic send_tick(input logic key);
        int gap;
        if ($urandom_range(0, 47) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_key_down <= key;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    task automatic send_run(input logic key, input int count);
        repeat (count) send_tick(key);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_thresholds(input int deb, input int lim, input int win);
        drain_results();
        write_reg(REG_DEBOUNCE_TICKS, deb[7:0]);
        write_reg(REG_LONG_LIMIT, lim[7:0]);
        write_reg(REG_DOUBLE_WINDOW, win[7:0]);
        cfg_deb = deb;
        cfg_lim = lim;
        cfg_win = win;
        settings_used++;
    endtask

    // press and release shapes around the current thresholds, plus some noise
    task automatic run_random(input int budget);
        int target;
        int kind;
        int lo;
        int hi;
        int hold;
        int gap;
        target = ticks_sent + budget;
        while (ticks_sent < target) begin
            kind = $urandom_range(0, 9);
            lo   = (cfg_deb == 0) ? 1 : cfg_deb;
            case (kind)
                0, 1, 2, 3: begin
                    // short press
                    hi = (cfg_lim < lo) ? lo : cfg_lim;
                    if (hi > lo + 8) hi = lo + 8;
                    hold = $urandom_range(lo, hi);
                end
                4, 5: hold = cfg_lim + 1 + $urandom_range(0, 3);
                6: hold = (cfg_deb > 1) ? $urandom_range(1, cfg_deb - 1) : 1;
                7: hold = 0;
                default: hold = $urandom_range(1, 20);
            endcase
            if (hold == 0) begin
                // bounce noise
                repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
            end else begin
                case ($urandom_range(0, 3))
                    0: gap = cfg_win + $urandom_range(1, 2);
                    1: gap = 1;
                    default: gap = $urandom_range(1, (cfg_win < 1) ? 1 :
                                                     (cfg_win > 10) ? 10 : cfg_win);
                endcase
                send_run(1'b1, hold);
                send_run(1'b0, gap);
            end
        end
    endtask

    // result side: random stalls, steady stretches and two long hold-offs
    initial begin
        int  stall;
        bit  rx_steady;
        rx_steady = 1'b0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 47) == 0) rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 5);
            if (results_taken == 400 || results_taken == 1200) stall = 120;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    // stimulus and verdict
    initial begin
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_key_down <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed clicks with tight thresholds
        set_thresholds(1, 3, 2);
        foreach (press_script[i]) send_tick(press_script[i]);

        // reset values, then the extremes and the odd corners
        set_thresholds(DEBOUNCE_RESET, LONG_RESET, WINDOW_RESET);
        run_random(200);
        set_thresholds(1, 0, 0);
        run_random(150);
        set_thresholds(255, 255, 255);
        run_random(200);
        set_thresholds(0, 254, 254);
        run_random(100);
        set_thresholds(3, 1, 5);
        run_random(150);
        repeat (3) begin
            set_thresholds($urandom_range(1, 8), $urandom_range(0, 20), $urandom_range(0, 12));
            run_random(100);
        end
        set_thresholds($urandom_range(1, 255), $urandom_range(0, 254), $urandom_range(0, 254));
        run_random(100);
        drain_results();

        $display("run covered %0d key ticks over %0d threshold settings", ticks_sent,
                 settings_used);
        $display("events seen: %0d single, %0d double, %0d long", singles_seen,
                 doubles_seen, longs_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/kcc_pkg.sv
hdl/key_click_classifier_top.sv
bench/kcc_result_checker.sv
bench/tb_key_click_classifier_top.sv
